### hw/rtl/set_pkg.sv
// shared constants, types and helpers for the sobel edge threshold block
`default_nettype none
package set_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W    = 11;
  localparam int PIXEL_W  = 8;
  localparam int SUM_W    = 11;
  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int COL_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 1);
  localparam int KSUM_W   = PIXEL_W + 2;

  localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_EDGE_LIMIT   = 2'd2
  } reg_index_t;

  // per-item control carried from the input register to the window stage
  typedef struct packed {
    logic clear_window;
    logic row_ge1;
    logic row_ge2;
    logic mem_write;
    logic has_result;
    logic frame_end;
  } item_ctl_t;

  function automatic logic [COL_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) begin
      x = 32'd1;
    end else if (x > 32'(MAX_WIDTH)) begin
      x = 32'(MAX_WIDTH);
    end
    return COL_W'(x);
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) begin
      x = 32'd1;
    end else if (x > 32'(MAX_HEIGHT)) begin
      x = 32'(MAX_HEIGHT);
    end
    return ROW_W'(x);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/set_pixel_if.sv
// valid/ready channel carrying one grey pixel word
`default_nettype none
interface set_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [set_pkg::PIXEL_W-1:0]    pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

### hw/rtl/set_result_if.sv
// valid/ready channel carrying one edge result word
`default_nettype none
interface set_result_if;
  logic                           valid;
  logic                           ready;
  logic [set_pkg::PIXEL_W-1:0]    edge_pixel;
  logic [set_pkg::SUM_W-1:0]      gradient_sum;
  logic                           frame_end;

  modport source (output valid, output edge_pixel, output gradient_sum, output frame_end,
                  input ready);
  modport sink   (input valid, input edge_pixel, input gradient_sum, input frame_end,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/sobel_edge_threshold_unit.sv
// top level of the 3x3 sobel edge detector with threshold
//
// pixels: grey words in raster order over an extended raster of
//   (height+1) x (width+1) positions; the word at a padding position
//   (last column or last row) is ignored and taken as zero.
// results: one word per position with row >= 1 and column >= 1, for the
//   centre one row and one column back; frame_end marks the last one.
// cfg: write cfg_index/cfg_data with cfg_write, only while the block is
//   idle; writing width or height restarts the frame.
// path: an accepted input word is held in the input register, and its result
//   is then held in the output register.
// throughput: one pixel word per cycle while results are taken; each line store
//   does one read at accept and one write as the word leaves the input register.
// reset: counters, window and the pipeline valid bits clear; registers
//   return to 640 x 480 with limit 127. Line store contents are never
//   read before they are written in the frame, so they need no clearing.
// stall: while the result word waits, the input register holds and
//   pixels.ready drops only once it is also full.
`default_nettype none
module sobel_edge_threshold_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  set_pixel_if.sink                        pixels,
  set_result_if.source                     results,
  input  wire logic                        cfg_write,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [set_pkg::CFG_W-1:0]   cfg_data
);

  logic [set_pkg::CFG_W-1:0] image_width;
  logic [set_pkg::CFG_W-1:0] image_height;
  logic [set_pkg::CFG_W-1:0] edge_limit;

  logic [set_pkg::COL_W-1:0] column_count;
  logic [set_pkg::ROW_W-1:0] row_count;
  logic [set_pkg::COL_W-1:0] width_used;
  logic [set_pkg::ROW_W-1:0] height_used;
  logic                      col_pad, row_pad;

  logic                          s1_valid;
  set_pkg::item_ctl_t            s1_ctl;
  set_pkg::item_ctl_t            ctl_next;
  logic [set_pkg::PIXEL_W-1:0]   s1_bot;
  logic [set_pkg::ADDR_W-1:0]    s1_addr;

  logic                          res_valid;
  logic [set_pkg::PIXEL_W-1:0]   res_edge;
  logic [set_pkg::SUM_W-1:0]     res_sum;
  logic                          res_frame_end;

  logic advance_en, accept, advance;
  logic [set_pkg::PIXEL_W-1:0] upper_rd, lower_rd, top, mid;
  logic [set_pkg::SUM_W-1:0]   gradient;
  logic [set_pkg::PIXEL_W-1:0] edge_value;

  assign width_used  = set_pkg::clamp_width(image_width);
  assign height_used = set_pkg::clamp_height(image_height);
  assign col_pad     = column_count >= width_used;
  assign row_pad     = row_count >= height_used;

  assign advance_en   = !res_valid || results.ready;
  assign pixels.ready = !s1_valid || advance_en;
  assign accept       = pixels.valid && pixels.ready;
  assign advance      = s1_valid && advance_en;

  always_comb begin
    ctl_next.clear_window = column_count == '0;
    ctl_next.row_ge1      = row_count >= set_pkg::ROW_W'(1);
    ctl_next.row_ge2      = row_count >= set_pkg::ROW_W'(2);
    ctl_next.mem_write    = !col_pad;
    ctl_next.has_result   = (row_count != '0) && (column_count != '0);
    ctl_next.frame_end    = col_pad && row_pad;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= set_pkg::CFG_W'(640);
      image_height <= set_pkg::CFG_W'(480);
      edge_limit   <= set_pkg::CFG_W'(127);
    end else if (cfg_write) begin
      case (cfg_index)
        set_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        set_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        set_pkg::REG_EDGE_LIMIT:   edge_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_write && (cfg_index == set_pkg::REG_IMAGE_WIDTH ||
                               cfg_index == set_pkg::REG_IMAGE_HEIGHT)) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_pad) begin
        column_count <= '0;
        row_count    <= row_pad ? '0 : row_count + set_pkg::ROW_W'(1);
      end else begin
        column_count <= column_count + set_pkg::COL_W'(1);
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl  <= ctl_next;
      s1_bot  <= (col_pad || row_pad) ? '0 : pixels.pixel;
      s1_addr <= column_count[set_pkg::ADDR_W-1:0];
    end
  end

  set_line_buffer u_line_buffer (
    .clk      (clk),
    .rd_en    (accept && !col_pad),
    .rd_addr  (column_count[set_pkg::ADDR_W-1:0]),
    .wr_en    (advance && s1_ctl.mem_write),
    .wr_addr  (s1_addr),
    .wr_bot   (s1_bot),
    .upper_rd (upper_rd),
    .lower_rd (lower_rd)
  );

  // rows above the image read as zero; padding columns give zeros too
  assign top = (s1_ctl.mem_write && s1_ctl.row_ge2) ? upper_rd : '0;
  assign mid = (s1_ctl.mem_write && s1_ctl.row_ge1) ? lower_rd : '0;

  set_window_filter u_window_filter (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .clear      (s1_ctl.clear_window),
    .top        (top),
    .mid        (mid),
    .bot        (s1_bot),
    .limit      (edge_limit),
    .gradient   (gradient),
    .edge_value (edge_value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && s1_ctl.has_result) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_ctl.has_result) begin
      res_edge      <= edge_value;
      res_sum       <= gradient;
      res_frame_end <= s1_ctl.frame_end;
    end
  end

  assign results.valid        = res_valid;
  assign results.edge_pixel   = res_edge;
  assign results.gradient_sum = res_sum;
  assign results.frame_end    = res_frame_end;

endmodule
`default_nettype wire

### hw/rtl/set_line_buffer.sv
// two line stores holding the previous image rows, registered read
`default_nettype none
module set_line_buffer (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [set_pkg::ADDR_W-1:0]    rd_addr,
  input  wire logic                          wr_en,
  input  wire logic [set_pkg::ADDR_W-1:0]    wr_addr,
  input  wire logic [set_pkg::PIXEL_W-1:0]   wr_bot,
  output logic      [set_pkg::PIXEL_W-1:0]   upper_rd,
  output logic      [set_pkg::PIXEL_W-1:0]   lower_rd
);

  logic [set_pkg::PIXEL_W-1:0] upper_mem [set_pkg::MAX_WIDTH];
  logic [set_pkg::PIXEL_W-1:0] lower_mem [set_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd <= upper_mem[rd_addr];
      lower_rd <= lower_mem[rd_addr];
    end
  end

  // rows shift down one store: upper takes the old lower word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= lower_rd;
      lower_mem[wr_addr] <= wr_bot;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/set_window_filter.sv
// 3x3 window registers and sobel gradient with threshold
`default_nettype none
module set_window_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic                          clear,
  input  wire logic [set_pkg::PIXEL_W-1:0]   top,
  input  wire logic [set_pkg::PIXEL_W-1:0]   mid,
  input  wire logic [set_pkg::PIXEL_W-1:0]   bot,
  input  wire logic [set_pkg::CFG_W-1:0]     limit,
  output logic      [set_pkg::SUM_W-1:0]     gradient,
  output logic      [set_pkg::PIXEL_W-1:0]   edge_value
);

  // window[row][col], row 0 top, col 2 newest
  logic [set_pkg::PIXEL_W-1:0] window      [3][3];
  logic [set_pkg::PIXEL_W-1:0] window_next [3][3];

  logic [set_pkg::KSUM_W-1:0] xp, xn, yp, yn;
  logic [set_pkg::KSUM_W-1:0] dx, dy;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      window_next[k][0] = clear ? '0 : window[k][1];
      window_next[k][1] = clear ? '0 : window[k][2];
    end
    window_next[0][2] = top;
    window_next[1][2] = mid;
    window_next[2][2] = bot;
  end

  always_comb begin
    xp = set_pkg::KSUM_W'(window_next[0][2]) + {1'b0, window_next[1][2], 1'b0}
       + set_pkg::KSUM_W'(window_next[2][2]);
    xn = set_pkg::KSUM_W'(window_next[0][0]) + {1'b0, window_next[1][0], 1'b0}
       + set_pkg::KSUM_W'(window_next[2][0]);
    yp = set_pkg::KSUM_W'(window_next[0][0]) + {1'b0, window_next[0][1], 1'b0}
       + set_pkg::KSUM_W'(window_next[0][2]);
    yn = set_pkg::KSUM_W'(window_next[2][0]) + {1'b0, window_next[2][1], 1'b0}
       + set_pkg::KSUM_W'(window_next[2][2]);
    dx = (xp >= xn) ? xp - xn : xn - xp;
    dy = (yp >= yn) ? yp - yn : yn - yp;
    gradient   = set_pkg::SUM_W'(dx) + set_pkg::SUM_W'(dy);
    edge_value = (gradient > limit) ? set_pkg::EDGE_ON : set_pkg::EDGE_OFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          window[r][c] <= '0;
        end
      end
    end else if (step) begin
      window <= window_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/set_checker.sv
// port-level checker for the sobel edge threshold block, bound to the top level
`default_nettype none
module set_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         res_valid,
  input wire logic                         res_ready,
  input wire logic [set_pkg::PIXEL_W-1:0]  edge_pixel,
  input wire logic [set_pkg::SUM_W-1:0]    gradient_sum
);

  // a result word waiting on the receiver stays offered
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  // result words are binary images
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (edge_pixel == set_pkg::EDGE_ON || edge_pixel == set_pkg::EDGE_OFF))
    else $error("edge pixel neither on nor off");

  // the gradient sum never exceeds the sobel maximum
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> gradient_sum <= set_pkg::SUM_W'(2040))
    else $error("gradient sum out of range");

  // an edge needs a sum above a non-negative limit
  assert property (@(posedge clk) disable iff (rst)
    res_valid && edge_pixel == set_pkg::EDGE_ON |-> gradient_sum != '0)
    else $error("edge marked with zero gradient");

  // reset leaves no result word offered
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word offered after reset");

endmodule

bind sobel_edge_threshold_unit set_checker u_set_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .edge_pixel   (results.edge_pixel),
  .gradient_sum (results.gradient_sum)
);
`default_nettype wire

### sim/sobel_edge_threshold_checker.sv
// checker that predicts sobel edge words from the observed pixel and register traffic
`default_nettype none
module sobel_edge_threshold_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  set_pixel_if                           pixels,
  set_result_if                          results,
  input  wire logic                      cfg_write,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [set_pkg::CFG_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending
);

  localparam logic [set_pkg::CFG_W-1:0] WIDTH_AT_RESET  = 11'd640;
  localparam logic [set_pkg::CFG_W-1:0] HEIGHT_AT_RESET = 11'd480;
  localparam logic [set_pkg::CFG_W-1:0] LIMIT_AT_RESET  = 11'd127;

  typedef struct packed {
    logic [set_pkg::PIXEL_W-1:0] edge_pixel;
    logic [set_pkg::SUM_W-1:0]   gradient_sum;
    logic                        frame_end;
  } edge_word_t;

  edge_word_t                  expected_edges[$];
  logic [set_pkg::CFG_W-1:0]   img_width;
  logic [set_pkg::CFG_W-1:0]   img_height;
  logic [set_pkg::CFG_W-1:0]   edge_limit;
  logic [set_pkg::PIXEL_W-1:0] upper_row [set_pkg::MAX_WIDTH];
  logic [set_pkg::PIXEL_W-1:0] lower_row [set_pkg::MAX_WIDTH];
  logic [set_pkg::PIXEL_W-1:0] win [3][3];
  int                          col_pos;
  int                          row_pos;
  int                          error_total;

  initial begin
    error_total = 0;
    mismatches  = 0;
    pending     = 0;
  end

  function automatic int fit_size(input logic [set_pkg::CFG_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // one step of the extended raster: shift the window, update the line stores, queue any result
  task automatic sobel_advance(input logic [set_pkg::PIXEL_W-1:0] px);
    int         w, h, c, r, xp, xn, yp, yn, gx, gy;
    logic [set_pkg::PIXEL_W-1:0] top, mid, bot;
    bit         col_pad, row_pad;
    edge_word_t e;
    w = fit_size(img_width, set_pkg::MAX_WIDTH);
    h = fit_size(img_height, set_pkg::MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    col_pad = (c >= w);
    row_pad = (r >= h);
    top = '0;
    mid = '0;
    bot = '0;
    if (!col_pad) begin
      if (r >= 2) top = upper_row[c];
      if (r >= 1) mid = lower_row[c];
      if (!row_pad) bot = px;
      upper_row[c] = lower_row[c];
      lower_row[c] = bot;
    end
    for (int k = 0; k < 3; k++) begin
      if (c == 0) begin
        win[k][0] = '0;
        win[k][1] = '0;
      end else begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
    if (r >= 1 && c >= 1) begin
      xp = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]);
      xn = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]);
      yp = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]);
      yn = int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]);
      gx = (xp >= xn) ? xp - xn : xn - xp;
      gy = (yp >= yn) ? yp - yn : yn - yp;
      e.edge_pixel   = (gx + gy > int'(edge_limit)) ? set_pkg::EDGE_ON : set_pkg::EDGE_OFF;
      e.gradient_sum = set_pkg::SUM_W'(gx + gy);
      e.frame_end    = col_pad && row_pad;
      expected_edges.push_back(e);
    end
    if (col_pad) begin
      col_pos = 0;
      row_pos = row_pad ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_result();
    edge_word_t want;
    if (expected_edges.size() == 0) begin
      $error("unexpected edge word: edge_pixel %0d gradient_sum %0d frame_end %0d",
             results.edge_pixel, results.gradient_sum, results.frame_end);
      error_total++;
    end else begin
      want = expected_edges.pop_front();
      if (results.edge_pixel !== want.edge_pixel) begin
        $error("edge_pixel: expected %0d, actual %0d", want.edge_pixel, results.edge_pixel);
        error_total++;
      end
      if (results.gradient_sum !== want.gradient_sum) begin
        $error("gradient_sum: expected %0d, actual %0d",
               want.gradient_sum, results.gradient_sum);
        error_total++;
      end
      if (results.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", want.frame_end, results.frame_end);
        error_total++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      img_width  = WIDTH_AT_RESET;
      img_height = HEIGHT_AT_RESET;
      edge_limit = LIMIT_AT_RESET;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] = '0;
        end
      end
      col_pos = 0;
      row_pos = 0;
      expected_edges.delete();
    end else begin
      // the word leaving now was predicted at an earlier edge
      if (results.valid && results.ready) check_result();
      if (cfg_write) begin
        case (cfg_index)
          set_pkg::REG_IMAGE_WIDTH: begin
            img_width = cfg_data;
            col_pos   = 0;
            row_pos   = 0;
          end
          set_pkg::REG_IMAGE_HEIGHT: begin
            img_height = cfg_data;
            col_pos    = 0;
            row_pos    = 0;
          end
          set_pkg::REG_EDGE_LIMIT: edge_limit = cfg_data;
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) sobel_advance(pixels.pixel);
    end
    pending    <= expected_edges.size();
    mismatches <= error_total;
  end

endmodule
`default_nettype wire

### sim/sobel_edge_threshold_unit_tb.sv
// testbench top: pixel stimulus, register writes, result drain and verdict
`default_nettype none
module sobel_edge_threshold_unit_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 250;

  typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_FLAT, TEXTURE_LOW} texture_t;
  typedef enum int {DRAIN_FULL, DRAIN_HALF, DRAIN_SPARSE, DRAIN_BURST, DRAIN_HOLD} drain_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [1:0]                cfg_index;
  logic [set_pkg::CFG_W-1:0] cfg_data;
  int                        mismatches;
  int                        pending;

  int                        burst_left;
  bit                        steady;
  logic [set_pkg::CFG_W-1:0] cur_w;
  logic [set_pkg::CFG_W-1:0] cur_h;

  set_pixel_if  pix_ch ();
  set_result_if res_ch ();

  sobel_edge_threshold_unit dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_ch),
    .results   (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sobel_edge_threshold_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pix_ch),
    .results    (res_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int frame_dim(input logic [set_pkg::CFG_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic [set_pkg::PIXEL_W-1:0] gen_pixel(
      input texture_t tex, input logic [set_pkg::PIXEL_W-1:0] base);
    case (tex)
      TEXTURE_NOISE:  return set_pkg::PIXEL_W'($urandom_range(0, 255));
      TEXTURE_BINARY: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      TEXTURE_FLAT:   return base;
      default:        return set_pkg::PIXEL_W'(base + $urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [set_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return set_pkg::CFG_W'($urandom_range(9, 24));
      default: return set_pkg::CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [set_pkg::CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 11'd2040;
      2:       return 11'd2047;
      3:       return set_pkg::CFG_W'($urandom_range(0, 2047));
      default: return set_pkg::CFG_W'($urandom_range(0, 700));
    endcase
  endfunction

  // bursts of words with random gaps, unless the phase runs steady
  task automatic send_pixel(input logic [set_pkg::PIXEL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= v;
    do @(posedge clk); while (!pix_ch.ready);
    burst_left--;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [set_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // sel: width, height, limit, unused index
  task automatic configure(input logic [set_pkg::CFG_W-1:0] w,
                           input logic [set_pkg::CFG_W-1:0] h,
                           input logic [set_pkg::CFG_W-1:0] lim, input bit [3:0] sel);
    if (sel[0]) begin
      write_reg(set_pkg::REG_IMAGE_WIDTH, w);
      cur_w = w;
    end
    if (sel[1]) begin
      write_reg(set_pkg::REG_IMAGE_HEIGHT, h);
      cur_h = h;
    end
    if (sel[2]) write_reg(set_pkg::REG_EDGE_LIMIT, lim);
    if (sel[3]) write_reg(REG_UNUSED, set_pkg::CFG_W'($urandom_range(0, 2047)));
    cfg_write <= 1'b0;
  endtask

  // stop offering, wait for every predicted word, then let the pipe drain
  task automatic settle(input int tail);
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  initial begin : result_drain
    drain_t mode;
    int     seg;
    bit     pressed;
    pressed = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = ($urandom_range(0, 9) == 0) ? DRAIN_HOLD : drain_t'($urandom_range(0, 3));
      seg  = $urandom_range(20, 200);
      for (int i = 0; i < seg; i++) begin
        // one long hold-off while words are still offered, so the input backs up
        if (!pressed && pix_ch.valid && res_ch.valid) begin
          pressed = 1'b1;
          res_ch.ready <= 1'b0;
          repeat (300) @(posedge clk);
        end
        case (mode)
          DRAIN_FULL:   res_ch.ready <= 1'b1;
          DRAIN_HALF:   res_ch.ready <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
          DRAIN_BURST:  res_ch.ready <= ((i % 8) < 5);
          default:      res_ch.ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [set_pkg::PIXEL_W-1:0] grid_3x3 [16];
    logic [set_pkg::PIXEL_W-1:0] grid_1x1 [4];
    logic [set_pkg::PIXEL_W-1:0] base;
    texture_t                    tex;
    int                          random_items;
    int                          frame_len;
    int                          count;
    bit                          first;

    // 3x3 image on a 4x4 extended raster; padding words are mostly nonzero to show they are ignored
    grid_3x3 = '{8'd255, 8'd0,   8'd255, 8'd255,
                 8'd0,   8'd255, 8'd0,   8'd255,
                 8'd255, 8'd255, 8'd0,   8'd0,
                 8'd255, 8'd255, 8'd255, 8'd255};
    grid_1x1 = '{8'd255, 8'd255, 8'd255, 8'd255};

    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= set_pkg::REG_IMAGE_WIDTH;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    burst_left   = 0;
    steady       = 1'b0;
    cur_w        = 11'd640;
    cur_h        = 11'd480;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sizes and limit as they come out of reset: row 0 and the start of row 1
    repeat (648) send_pixel(set_pkg::PIXEL_W'($urandom_range(0, 255)));
    settle(8);

    configure(11'd3, 11'd3, 11'd0, 4'b1111);
    foreach (grid_3x3[i]) send_pixel(grid_3x3[i]);
    settle(8);

    // zero sizes act as one, and nothing passes the top limit
    configure(11'd0, 11'd0, 11'd2047, 4'b0111);
    foreach (grid_1x1[i]) send_pixel(grid_1x1[i]);
    settle(8);

    random_items = 0;
    first = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      configure(pick_size(), pick_size(), pick_limit(),
                first ? 4'b0111 : 4'($urandom_range(0, 15)));
      first  = 1'b0;
      tex    = texture_t'($urandom_range(0, 3));
      base   = set_pkg::PIXEL_W'($urandom_range(0, 255));
      steady = ($urandom_range(0, 3) == 0);
      frame_len = (frame_dim(cur_w, set_pkg::MAX_WIDTH) + 1)
                * (frame_dim(cur_h, set_pkg::MAX_HEIGHT) + 1);
      // mostly whole frames, now and then a cut-off or overlong run
      if ($urandom_range(0, 4) == 0) begin
        count = $urandom_range(1, 2 * frame_len);
      end else begin
        count = frame_len * $urandom_range(1, 3);
      end
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      repeat (count) send_pixel(gen_pixel(tex, base));
      random_items += count;
      settle(8);
    end

    // oversized width clamps to the line store depth
    steady = 1'b0;
    configure(11'd2047, 11'd1, 11'd300, 4'b0111);
    repeat (1032) send_pixel(set_pkg::PIXEL_W'($urandom_range(0, 255)));
    settle(20);

    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sobel_edge_threshold_unit.f
hw/rtl/set_pkg.sv
hw/rtl/set_pixel_if.sv
hw/rtl/set_result_if.sv
hw/rtl/set_line_buffer.sv
hw/rtl/set_window_filter.sv
hw/rtl/sobel_edge_threshold_unit.sv
hw/rtl/set_checker.sv
sim/sobel_edge_threshold_checker.sv
sim/sobel_edge_threshold_unit_tb.sv
